[hw/rtl/dlfb_pkg.sv]
`timescale 1ns / 1ps
// dlfb_pkg: shared types, codes and rounding for the dense layer engine
// used by dlfb_front, dlfb_back, the top level and dlfb_checker, depends on nothing

package dlfb_pkg;

    localparam int MAX_IN_DEF    = 16;
    localparam int MAX_OUT_DEF   = 16;
    localparam int FRAC_BITS_DEF = 12;
    localparam int DATA_W        = 16;
    localparam int ACC_W         = 40;
    localparam int TDATA_W       = 24;

    localparam logic [4:0] SIZE_RST = 5'd16;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_INPUT  = 2'd2;
    localparam logic [1:0] CMD_GRAD   = 2'd3;

    localparam logic CFG_IN_SIZE  = 1'b0;
    localparam logic CFG_OUT_SIZE = 1'b1;

    typedef enum logic [1:0] {
        KIND_FWD   = 2'd0,
        KIND_WGRAD = 2'd1,
        KIND_BGRAD = 2'd2,
        KIND_DX    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WLOAD,
        OP_BLOAD,
        OP_XSTORE,
        OP_FWD,
        OP_GRAD,
        OP_GLAST
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRUN,
        ST_FDRAIN,
        ST_FEMIT,
        ST_GRUN,
        ST_GDRAIN,
        ST_GBIAS,
        ST_GDX
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [DATA_W-1:0]  value;
    } job_t;

    // round half up to frac bits, then saturate to 16 bits
    function automatic logic [DATA_W-1:0] round_sat(input logic signed [40:0] v,
                                                    input int frac);
        logic signed [40:0] t;
        t = v;
        if (frac > 0) begin
            t = v + (41'sd1 <<< (frac - 1));
        end
        t = t >>> frac;
        if (t > 41'sd32767) begin
            return 16'h7fff;
        end else if (t < -41'sd32768) begin
            return 16'h8000;
        end
        return t[DATA_W-1:0];
    endfunction

endpackage

[hw/rtl/dlfb_ram.sv]
`timescale 1ns / 1ps
// dlfb_ram: generic simple dual port ram, one write port, registered read
// depends on nothing

module dlfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/dlfb_front.sv]
`timescale 1ns / 1ps
// dlfb_front: accepts stream words, classifies them into jobs, two-entry job queue
// depends on dlfb_pkg

module dlfb_front #(
    parameter int MAX_IN  = dlfb_pkg::MAX_IN_DEF,
    parameter int MAX_OUT = dlfb_pkg::MAX_OUT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic [4:0]           ni,
    input  logic [5:0]           no,
    output logic                 job_valid,
    output dlfb_pkg::job_t       job,
    input  logic                 job_pop
);
    import dlfb_pkg::*;

    job_t       q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       cls;
    logic       push;

    always_comb begin
        cls.row   = s_tdata[3:0];
        cls.col   = s_tdata[7:4];
        cls.value = s_tdata[23:8];
        cls.op    = OP_NONE;
        case (s_tuser)
            CMD_WEIGHT: begin
                if (int'(cls.row) < MAX_OUT && int'(cls.col) < MAX_IN) begin
                    cls.op = OP_WLOAD;
                end
            end
            CMD_BIAS: begin
                if (int'(cls.row) < MAX_OUT) begin
                    cls.op = OP_BLOAD;
                end
            end
            CMD_INPUT: begin
                if (int'(cls.col) < MAX_IN) begin
                    cls.op = (int'(cls.col) == int'(ni) - 1) ? OP_FWD : OP_XSTORE;
                end
            end
            CMD_GRAD: begin
                if (int'(cls.row) < int'(no)) begin
                    cls.op = (int'(cls.row) == int'(no) - 1) ? OP_GLAST : OP_GRAD;
                end
            end
            default: cls.op = OP_NONE;
        endcase
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready && (cls.op != OP_NONE);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = ~wptr_reg;
        end
        if (job_pop) begin
            rptr_next = ~rptr_reg;
        end
        case ({push, job_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= cls;
        end
    end
endmodule

[hw/rtl/dlfb_back.sv]
`timescale 1ns / 1ps
// dlfb_back: job sequencer, stores, multiply-accumulate pipe and output register
// depends on dlfb_pkg and dlfb_ram

module dlfb_back #(
    parameter int MAX_IN    = dlfb_pkg::MAX_IN_DEF,
    parameter int MAX_OUT   = dlfb_pkg::MAX_OUT_DEF,
    parameter int FRAC_BITS = dlfb_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 job_valid,
    input  dlfb_pkg::job_t       job,
    output logic                 job_pop,
    input  logic [4:0]           ni,
    input  logic [5:0]           no,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);
    import dlfb_pkg::*;

    localparam int CW    = MAX_IN > 1 ? $clog2(MAX_IN) : 1;
    localparam int RW    = MAX_OUT > 1 ? $clog2(MAX_OUT) : 1;
    localparam int DEPTH = MAX_IN * MAX_OUT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;
    logic [5:0] row_reg, row_next;
    logic [4:0] col_reg, col_next;
    logic [4:0] dx_reg, dx_next;
    logic       glast_reg, glast_next;

    logic signed [DATA_W-1:0] dy_reg;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] x_reg    [MAX_IN];
    logic signed [DATA_W-1:0] bias_reg [MAX_OUT];
    logic signed [ACC_W-1:0]  acc_reg  [MAX_IN];

    logic                     v1_reg, v2_reg;
    logic [4:0]               c1_reg, c2_reg;
    logic signed [31:0]       pa_reg, pb_reg;

    logic              mv_reg;
    logic [23:0]       mdata_reg;
    logic [1:0]        muser_reg;
    logic              mlast_reg;

    logic              out_free, grad_mode, adv, issue, emit, ram_we;
    kind_t             e_kind;
    logic [3:0]        e_row, e_col;
    logic [DATA_W-1:0] e_val;
    logic              e_last;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] w_rd;
    logic signed [DATA_W-1:0] xop, wop;
    logic signed [40:0] fsum, asum;
    logic signed [ACC_W-1:0] asat;

    dlfb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_wram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (job.value),
        .re    (issue),
        .raddr (raddr),
        .rdata (w_rd)
    );

    assign waddr = AW'(int'(job.row) * MAX_IN + int'(job.col));
    assign raddr = AW'(int'(row_reg) * MAX_IN + int'(col_reg));

    assign out_free  = !mv_reg || m_tready;
    assign grad_mode = (state_reg == ST_GRUN) || (state_reg == ST_GDRAIN);
    assign adv       = !(v2_reg && grad_mode && !out_free);
    assign xop       = x_reg[c1_reg[CW-1:0]];
    assign wop       = $signed(w_rd);
    assign fsum      = 41'(sum_reg) + (41'(bias_reg[row_reg[RW-1:0]]) <<< FRAC_BITS);
    assign asum      = 41'(acc_reg[c2_reg[CW-1:0]]) + 41'(pa_reg);
    assign asat      = (asum[40] != asum[39]) ? {asum[40], {(ACC_W-1){~asum[40]}}}
                                              : asum[ACC_W-1:0];

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        dx_next    = dx_reg;
        glast_next = glast_reg;
        job_pop    = 1'b0;
        ram_we     = 1'b0;
        issue      = 1'b0;
        emit       = 1'b0;
        e_kind     = KIND_FWD;
        e_row      = 4'd0;
        e_col      = 4'd0;
        e_val      = '0;
        e_last     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop = 1'b1;
                    case (job.op)
                        OP_WLOAD: ram_we = 1'b1;
                        OP_FWD: begin
                            state_next = ST_FRUN;
                            row_next   = 6'd0;
                            col_next   = 5'd0;
                        end
                        OP_GRAD, OP_GLAST: begin
                            state_next = ST_GRUN;
                            row_next   = 6'(job.row);
                            col_next   = 5'd0;
                            glast_next = (job.op == OP_GLAST);
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FRUN, ST_GRUN: begin
                if (adv) begin
                    issue    = 1'b1;
                    col_next = col_reg + 5'd1;
                    if (col_reg == ni - 5'd1) begin
                        state_next = (state_reg == ST_FRUN) ? ST_FDRAIN : ST_GDRAIN;
                    end
                end
            end
            ST_FDRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_FEMIT;
                end
            end
            ST_GDRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_GBIAS;
                end
            end
            ST_FEMIT: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = KIND_FWD;
                    e_row  = row_reg[3:0];
                    e_val  = round_sat(fsum, FRAC_BITS);
                    e_last = (row_reg == no - 6'd1);
                    if (e_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        row_next   = row_reg + 6'd1;
                        col_next   = 5'd0;
                        state_next = ST_FRUN;
                    end
                end
            end
            ST_GBIAS: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = KIND_BGRAD;
                    e_row      = row_reg[3:0];
                    e_val      = dy_reg;
                    e_last     = !glast_reg;
                    dx_next    = 5'd0;
                    state_next = glast_reg ? ST_GDX : ST_IDLE;
                end
            end
            ST_GDX: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_DX;
                    e_col   = dx_reg[3:0];
                    e_val   = round_sat(41'(acc_reg[dx_reg[CW-1:0]]), FRAC_BITS);
                    e_last  = (dx_reg == ni - 5'd1);
                    dx_next = dx_reg + 5'd1;
                    if (e_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // weight gradient words leave straight from the pipe
        if (v2_reg && grad_mode && out_free) begin
            emit   = 1'b1;
            e_kind = KIND_WGRAD;
            e_row  = row_reg[3:0];
            e_col  = c2_reg[3:0];
            e_val  = round_sat(41'(pb_reg), FRAC_BITS);
            e_last = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= 6'd0;
            col_reg   <= 5'd0;
            dx_reg    <= 5'd0;
            glast_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            mv_reg    <= 1'b0;
            for (int i = 0; i < MAX_IN; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            dx_reg    <= dx_next;
            glast_reg <= glast_next;
            if (adv) begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
            end
            if (emit) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            if (v2_reg && grad_mode && adv) begin
                acc_reg[c2_reg[CW-1:0]] <= asat;
            end
            if (state_reg == ST_GDX && out_free) begin
                acc_reg[dx_reg[CW-1:0]] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop && (job.op == OP_XSTORE || job.op == OP_FWD)) begin
            x_reg[CW'(job.col)] <= job.value;
        end
        if (job_pop && job.op == OP_BLOAD) begin
            bias_reg[RW'(job.row)] <= job.value;
        end
        if (job_pop && (job.op == OP_GRAD || job.op == OP_GLAST)) begin
            dy_reg <= job.value;
        end
        if (adv) begin
            c1_reg <= col_reg;
            c2_reg <= c1_reg;
            pa_reg <= wop * (grad_mode ? dy_reg : xop);
            pb_reg <= dy_reg * xop;
        end
        if (state_reg == ST_IDLE || (state_reg == ST_FEMIT && out_free)) begin
            sum_reg <= '0;
        end else if (v2_reg && !grad_mode) begin
            sum_reg <= sum_reg + ACC_W'(pa_reg);
        end
        if (emit) begin
            mdata_reg <= {e_val, e_col, e_row};
            muser_reg <= e_kind;
            mlast_reg <= e_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;
endmodule

[hw/rtl/dense_layer_forward_backward_unit.sv]
`timescale 1ns / 1ps
// dense_layer_forward_backward_unit: top level, size registers, front and back
// depends on dlfb_pkg, dlfb_front, dlfb_back
// the gradient word of the last row also brings out the input gradient words
// throughput: one multiply-accumulate per cycle while no stalled result word holds
// a gradient pass; set by the single weight ram read port
// reset: synchronous, clears control, queue and input gradient sums; sizes return to 16

module dense_layer_forward_backward_unit #(
    parameter int MAX_IN    = dlfb_pkg::MAX_IN_DEF,
    parameter int MAX_OUT   = dlfb_pkg::MAX_OUT_DEF,
    parameter int FRAC_BITS = dlfb_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row, col, value
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // row_res, col_res, value_res
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    import dlfb_pkg::*;

    logic [4:0] in_size_reg, out_size_reg;
    logic [4:0] ni;
    logic [5:0] no;
    logic       job_valid, job_pop;
    job_t       job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_size_reg  <= SIZE_RST;
            out_size_reg <= SIZE_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_IN_SIZE) begin
                in_size_reg <= cfg_data;
            end else begin
                out_size_reg <= cfg_data;
            end
        end
    end

    assign ni = (in_size_reg == 5'd0) ? 5'd1
              : (int'(in_size_reg) > MAX_IN) ? 5'(MAX_IN) : in_size_reg;
    assign no = (out_size_reg == 5'd0) ? 6'd1
              : (int'(out_size_reg) > MAX_OUT) ? 6'(MAX_OUT) : 6'(out_size_reg);

    dlfb_front #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .ni        (ni),
        .no        (no),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    dlfb_back #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .ni        (ni),
        .no        (no),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );
endmodule

[hw/rtl/dlfb_checker.sv]
`timescale 1ns / 1ps
// dlfb_checker: port-level checks on the result stream, bound to the top level
// depends on dlfb_pkg and dense_layer_forward_backward_unit

module dlfb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import dlfb_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    a_fwd_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_FWD || m_tuser == KIND_BGRAD) |-> m_tdata[7:4] == 4'd0)
        else $error("forward or bias word with nonzero column");

    a_dx_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DX |-> m_tdata[3:0] == 4'd0)
        else $error("input gradient word with nonzero row");

    a_wgrad_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_WGRAD |-> !m_tlast)
        else $error("weight gradient word marked last");
endmodule

bind dense_layer_forward_backward_unit dlfb_checker u_dlfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
